FILE: rtl/dhs_pkg.sv
// ----------------------------------------------------------------------------
// dhs_pkg
// Shared types and constants for the digest hash set: table geometry,
// FNV-1a constants and the control structs between the sequencer and table.
// ----------------------------------------------------------------------------
`default_nettype none

package dhs_pkg;

   // Table geometry
   localparam int CAPACITY     = 64;
   localparam int HALF_CAP     = CAPACITY / 2;
   localparam int SLOT_W       = $clog2(CAPACITY);
   localparam int DIGEST_WORDS = 4;
   localparam int WORD_W       = $clog2(DIGEST_WORDS);
   localparam int ADDR_W       = SLOT_W + WORD_W;
   localparam int DEPTH        = CAPACITY * DIGEST_WORDS;
   localparam int COUNT_W      = $clog2(HALF_CAP + 1);
   localparam int DATA_W       = 64;
   localparam int DIGEST_W     = DIGEST_WORDS * DATA_W;
   localparam int BYTE_W       = 8;
   localparam int DIGEST_BYTES = 32;
   localparam int CNT_W        = $clog2(DIGEST_BYTES);

   // FNV-1a 64: prime = 2^40 + 2^8 + 0xB3
   localparam logic [DATA_W-1:0] FNV_OFFSET    = 64'hCBF29CE484222325;
   localparam logic [BYTE_W-1:0] FNV_PRIME_LOW = 8'hB3;
   localparam int                FNV_SHIFT_HI  = 40;
   localparam int                FNV_SHIFT_LO  = 8;

   typedef enum logic {
      FUNC_LOOKUP = 1'b0,
      FUNC_INSERT = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_HOME,
      ST_PROBE,
      ST_CMP,
      ST_WRITE,
      ST_DONE
   } state_type;

   // Sequencer to table
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic              set_occ;
      logic [ADDR_W-1:0] addr;
   } tbl_ctrl_type;

   // Table to sequencer
   typedef struct packed {
      logic               occ;
      logic               full;
      logic [COUNT_W-1:0] count;
   } tbl_stat_type;

endpackage

`default_nettype wire

FILE: rtl/digest_hash_set_top.sv
// ----------------------------------------------------------------------------
// digest_hash_set_top
// Set of 256-bit digests in a linearly probed table, FNV-1a 64 hashed.
// ----------------------------------------------------------------------------
// One transaction at a time. After the accept cycle the digest is hashed one
// byte per cycle through the FNV unit, then the home slot is formed. Each
// probed slot has its occupied flag checked, and an occupied slot has its
// four words read and compared through the single memory read port. An
// insert of a new digest then writes its four words, and the result register
// is loaded. A result waits in its own register, so the next transaction is
// accepted while it is still stalled.
`default_nettype none

module digest_hash_set_top
   import dhs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_func,
   input  wire logic [DATA_W-1:0] req_digest_w0,
   input  wire logic [DATA_W-1:0] req_digest_w1,
   input  wire logic [DATA_W-1:0] req_digest_w2,
   input  wire logic [DATA_W-1:0] req_digest_w3,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_hit,
   output logic      [SLOT_W-1:0] rsp_slot_index,
   output logic                   rsp_refused
);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                match_ff, match_in;
   logic                hit_ff, hit_in;
   logic                refused_ff, refused_in;
   func_type            func_ff;
   logic [DIGEST_W-1:0] dig_ff, dig_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_slot_ld;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_refused_ff;

   logic                req_take;
   logic                hash_init, hash_step;
   logic [DATA_W-1:0]   hash;
   logic [DATA_W-1:0]   rd_data;
   logic                word_eq;
   tbl_ctrl_type        tbl_ctrl;
   tbl_stat_type        tbl_stat;

   dhs_fnv u_fnv (
      .clock     (clock),
      .reset     (reset),
      .init      (hash_init),
      .step      (hash_step),
      .data_byte (dig_ff[DIGEST_W-1 -: BYTE_W]),
      .hash      (hash)
   );

   dhs_table u_table (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (tbl_ctrl),
      .wr_data (dig_ff[DIGEST_W-1 -: DATA_W]),
      .rd_data (rd_data),
      .stat    (tbl_stat)
   );

   assign req_take = req_valid && !req_stall;
   assign word_eq  = (rd_data == dig_ff[DIGEST_W-1 -: DATA_W]);

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      slot_ff    <= slot_in;
      match_ff   <= match_in;
      hit_ff     <= hit_in;
      refused_ff <= refused_in;
      dig_ff     <= dig_in;
      if (req_take) begin
         func_ff <= func_type'(req_func);
      end
      if (rsp_slot_ld) begin
         rsp_hit_ff     <= hit_ff;
         rsp_slot_ff    <= slot_ff;
         rsp_refused_ff <= refused_ff;
      end
   end

   // next state and table control
   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      slot_in          = slot_ff;
      match_in         = match_ff;
      hit_in           = hit_ff;
      refused_in       = refused_ff;
      dig_in           = dig_ff;
      hash_init        = 1'b0;
      hash_step        = 1'b0;
      rsp_slot_ld      = 1'b0;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      req_stall        = 1'b1;
      tbl_ctrl.rd_en   = 1'b0;
      tbl_ctrl.wr_en   = 1'b0;
      tbl_ctrl.set_occ = 1'b0;
      tbl_ctrl.addr    = {slot_ff, cnt_ff[WORD_W-1:0]};

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dig_in    = {req_digest_w0, req_digest_w1, req_digest_w2, req_digest_w3};
               cnt_in    = '0;
               hash_init = 1'b1;
               state_in  = ST_HASH;
            end
         end
         // one byte per cycle; the digest rotates back into place after all 32 bytes
         ST_HASH: begin
            hash_step = 1'b1;
            dig_in    = {dig_ff[DIGEST_W-BYTE_W-1:0], dig_ff[DIGEST_W-1 -: BYTE_W]};
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIGEST_BYTES - 1)) begin
               state_in = ST_HOME;
            end
         end
         ST_HOME: begin
            slot_in  = hash[SLOT_W-1:0];
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            cnt_in   = '0;
            match_in = 1'b1;
            if (tbl_stat.occ) begin
               state_in = ST_CMP;
            end else begin
               hit_in     = 1'b0;
               refused_in = (func_ff == FUNC_INSERT) && tbl_stat.full;
               if ((func_ff == FUNC_INSERT) && !tbl_stat.full) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         // read four words, compare each in the cycle after its read
         ST_CMP: begin
            tbl_ctrl.rd_en = (cnt_ff < CNT_W'(DIGEST_WORDS));
            cnt_in         = cnt_ff + CNT_W'(1);
            if (cnt_ff != '0) begin
               match_in = match_ff && word_eq;
               dig_in   = {dig_ff[DIGEST_W-DATA_W-1:0], dig_ff[DIGEST_W-1 -: DATA_W]};
            end
            if (cnt_ff == CNT_W'(DIGEST_WORDS)) begin
               if (match_ff && word_eq) begin
                  hit_in     = 1'b1;
                  refused_in = 1'b0;
                  state_in   = ST_DONE;
               end else begin
                  slot_in  = slot_ff + SLOT_W'(1);
                  state_in = ST_PROBE;
               end
            end
         end
         ST_WRITE: begin
            tbl_ctrl.wr_en = 1'b1;
            dig_in         = {dig_ff[DIGEST_W-DATA_W-1:0], dig_ff[DIGEST_W-1 -: DATA_W]};
            cnt_in         = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIGEST_WORDS - 1)) begin
               tbl_ctrl.set_occ = 1'b1;
               state_in         = ST_DONE;
            end
         end
         // hand over once the result register is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_slot_ld  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_refused    = rsp_refused_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      tbl_stat.count <= COUNT_W'(HALF_CAP))
      else $error("entry count above half capacity");

   a_write_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> !tbl_stat.occ)
      else $error("insert writing into an occupied slot");

   a_refused_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_refused))
      else $error("result both hit and refused");

   a_accept_hash: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_HASH))
      else $error("accepted transaction did not start hashing");

endmodule

`default_nettype wire

FILE: rtl/dhs_fnv.sv
// ----------------------------------------------------------------------------
// dhs_fnv
// Byte-serial FNV-1a 64 hash unit: one byte folded in per cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module dhs_fnv
   import dhs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              init,
   input  wire logic              step,
   input  wire logic [BYTE_W-1:0] data_byte,
   output logic      [DATA_W-1:0] hash
);

   logic [DATA_W-1:0] hash_ff;
   logic [DATA_W-1:0] hash_in;
   logic [DATA_W-1:0] mix;
   logic [DATA_W-1:0] prod;

   // xor the byte in, then multiply by the prime as shifts plus a narrow product
   always_comb begin
      mix  = hash_ff ^ {{(DATA_W-BYTE_W){1'b0}}, data_byte};
      prod = mix * {{(DATA_W-BYTE_W){1'b0}}, FNV_PRIME_LOW};
      hash_in = hash_ff;
      if (init) begin
         hash_in = FNV_OFFSET;
      end else if (step) begin
         hash_in = prod + (mix << FNV_SHIFT_LO) + (mix << FNV_SHIFT_HI);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_OFFSET;
      end else begin
         hash_ff <= hash_in;
      end
   end

   assign hash = hash_ff;

endmodule

`default_nettype wire

FILE: rtl/dhs_table.sv
// ----------------------------------------------------------------------------
// dhs_table
// Digest word memory, occupied flags per slot and the entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module dhs_table
   import dhs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tbl_ctrl_type      ctrl,
   input  wire logic [DATA_W-1:0] wr_data,
   output logic      [DATA_W-1:0] rd_data,
   output tbl_stat_type           stat
);

   logic [DATA_W-1:0]   mem [DEPTH];
   logic [DATA_W-1:0]   rd_data_ff;
   logic [CAPACITY-1:0] occ_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [SLOT_W-1:0]   slot;

   assign slot = ctrl.addr[ADDR_W-1:WORD_W];

   // digest words: one port, registered read
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[ctrl.addr];
      end
   end

   // occupancy and count
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= '0;
         count_ff <= '0;
      end else if (ctrl.set_occ) begin
         occ_ff[slot] <= 1'b1;
         count_ff     <= count_ff + COUNT_W'(1);
      end
   end

   assign rd_data    = rd_data_ff;
   assign stat.occ   = occ_ff[slot];
   assign stat.full  = (count_ff >= COUNT_W'(HALF_CAP));
   assign stat.count = count_ff;

endmodule

`default_nettype wire

FILE: bench/digest_hash_set_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digest_hash_set_top_tb
// Self-checking bench for the FNV-1a hashed, linearly probed digest set.
// A short table of directed requests (empty table, all-zero and all-ones
// digests, duplicates, probe chains that wrap past the last slot, digests
// that share leading words with an earlier one) is followed by random phases. These mix
// stored, fresh, slot-targeted and near-miss digests under varying sender
// idling and receiver stalls, plus one long receiver hold-off. Every result
// transaction is compared field by field with an in-order prediction.
// ----------------------------------------------------------------------------

module digest_hash_set_top_tb
   import dhs_pkg::*;
();

   localparam int          TIMEOUT_CYCLES = 2_000_000;
   localparam int          DRAIN_CYCLES   = 300;
   localparam int          LONG_HOLD      = 600;
   localparam logic [63:0] FNV64_BASIS    = 64'hCBF2_9CE4_8422_2325;
   localparam logic [63:0] FNV64_PRIME    = 64'h0000_0100_0000_01B3;

   // d[0] is word 0 (bytes 0..7)
   typedef logic [DIGEST_WORDS-1:0][DATA_W-1:0] digest_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              refused;
   } probe_result_type;

   // How a directed row gets its digest
   typedef enum logic [1:0] {
      SRC_WORDS,   // literal words
      SRC_AGAIN,   // same digest as an earlier row
      SRC_HOMED,   // random digest whose home slot is arg
      SRC_NEAR     // keeps arg leading words of an earlier row, same home slot
   } digest_src_type;

   typedef struct packed {
      func_type       func;
      digest_src_type src;
      logic [7:0]     arg;
      logic [7:0]     ref_row;
      logic           typed;    // hit and refused below are the expected values
      logic           hit;
      logic           refused;
      digest_type     words;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 21;

   localparam digest_type ZERO_DIGEST = '0;
   localparam digest_type ONES_DIGEST = '1;
   localparam digest_type MIXED_DIGEST = {64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF,
                                          64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
   localparam digest_type SPARSE_DIGEST = {64'h0, 64'h8000_0000_0000_0000,
                                           64'h0000_0000_0000_0001, 64'h8000_0000_0000_0001};

   directed_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      // empty table: nothing can hit
      '{FUNC_LOOKUP, SRC_WORDS, 8'd0,  8'd0,  1'b1, 1'b0, 1'b0, ZERO_DIGEST},
      '{FUNC_LOOKUP, SRC_WORDS, 8'd0,  8'd0,  1'b1, 1'b0, 1'b0, ONES_DIGEST},
      '{FUNC_INSERT, SRC_WORDS, 8'd0,  8'd0,  1'b1, 1'b0, 1'b0, ZERO_DIGEST},
      // duplicate insert and lookup of a stored digest
      '{FUNC_INSERT, SRC_AGAIN, 8'd0,  8'd0,  1'b1, 1'b1, 1'b0, ZERO_DIGEST},
      '{FUNC_LOOKUP, SRC_AGAIN, 8'd0,  8'd0,  1'b1, 1'b1, 1'b0, ZERO_DIGEST},
      '{FUNC_INSERT, SRC_WORDS, 8'd0,  8'd0,  1'b1, 1'b0, 1'b0, ONES_DIGEST},
      '{FUNC_INSERT, SRC_WORDS, 8'd0,  8'd0,  1'b1, 1'b1, 1'b0, ONES_DIGEST},
      '{FUNC_INSERT, SRC_WORDS, 8'd0,  8'd0,  1'b0, 1'b0, 1'b0, MIXED_DIGEST},
      // chain homed on the last slot, wrapping to slot 0
      '{FUNC_INSERT, SRC_HOMED, 8'd63, 8'd0,  1'b0, 1'b0, 1'b0, ZERO_DIGEST},
      '{FUNC_INSERT, SRC_HOMED, 8'd63, 8'd0,  1'b0, 1'b0, 1'b0, ZERO_DIGEST},
      '{FUNC_INSERT, SRC_HOMED, 8'd63, 8'd0,  1'b0, 1'b0, 1'b0, ZERO_DIGEST},
      '{FUNC_LOOKUP, SRC_AGAIN, 8'd0,  8'd9,  1'b0, 1'b0, 1'b0, ZERO_DIGEST},
      // same home, digests that match an earlier one in their leading words only
      '{FUNC_INSERT, SRC_NEAR,  8'd3,  8'd8,  1'b0, 1'b0, 1'b0, ZERO_DIGEST},
      '{FUNC_INSERT, SRC_NEAR,  8'd1,  8'd9,  1'b0, 1'b0, 1'b0, ZERO_DIGEST},
      '{FUNC_LOOKUP, SRC_NEAR,  8'd2,  8'd10, 1'b0, 1'b0, 1'b0, ZERO_DIGEST},
      '{FUNC_LOOKUP, SRC_AGAIN, 8'd0,  8'd12, 1'b0, 1'b0, 1'b0, ZERO_DIGEST},
      '{FUNC_INSERT, SRC_AGAIN, 8'd0,  8'd13, 1'b0, 1'b0, 1'b0, ZERO_DIGEST},
      '{FUNC_LOOKUP, SRC_HOMED, 8'd0,  8'd0,  1'b0, 1'b0, 1'b0, ZERO_DIGEST},
      '{FUNC_INSERT, SRC_WORDS, 8'd0,  8'd0,  1'b0, 1'b0, 1'b0, SPARSE_DIGEST},
      '{FUNC_LOOKUP, SRC_WORDS, 8'd0,  8'd0,  1'b1, 1'b1, 1'b0, ONES_DIGEST},
      '{FUNC_LOOKUP, SRC_NEAR,  8'd0,  8'd18, 1'b0, 1'b0, 1'b0, ZERO_DIGEST}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_func = 1'b0;
   logic [DATA_W-1:0] req_digest_w0 = '0;
   logic [DATA_W-1:0] req_digest_w1 = '0;
   logic [DATA_W-1:0] req_digest_w2 = '0;
   logic [DATA_W-1:0] req_digest_w3 = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_hit;
   logic [SLOT_W-1:0] rsp_slot_index;
   logic              rsp_refused;

   // Predicted table contents
   digest_type digest_table [CAPACITY];
   logic       slot_taken [CAPACITY];
   int         stored_count = 0;

   probe_result_type expected_results [$];
   digest_type       digest_pool [$];
   digest_type       row_digest [0:DIRECTED_ROWS-1];

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic rsp_hold = 1'b0;
   int   cycle_count = 0;
   int   mismatches = 0;
   int   results_checked = 0;
   int   lookups_sent = 0;
   int   inserts_sent = 0;
   int   hits_predicted = 0;
   int   refusals_predicted = 0;

   digest_hash_set_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_digest_w0  (req_digest_w0),
      .req_digest_w1  (req_digest_w1),
      .req_digest_w2  (req_digest_w2),
      .req_digest_w3  (req_digest_w3),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_slot_index (rsp_slot_index),
      .rsp_refused    (rsp_refused)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // FNV-1a 64 over bytes 0..31, byte 0 in the top bits of word 0
   function automatic logic [63:0] fnv1a_digest(input digest_type d);
      logic [63:0] h;
      int          i;
      h = FNV64_BASIS;
      for (i = 0; i < DIGEST_BYTES; i++) begin
         h = (h ^ {56'h0, d[i / 8][56 - 8 * (i % 8) +: 8]}) * FNV64_PRIME;
      end
      return h;
   endfunction

   function automatic int home_slot(input digest_type d);
      logic [63:0] h;
      h = fnv1a_digest(d);
      return int'(h[SLOT_W-1:0]);
   endfunction

   // Probe walk and table update for one accepted request
   function automatic probe_result_type predict_request(input func_type f,
                                                        input digest_type d);
      int               slot;
      int               walked;
      probe_result_type res;
      slot = home_slot(d);
      for (walked = 0; walked < CAPACITY; walked++) begin
         if (!slot_taken[slot] || digest_table[slot] == d) break;
         slot = (slot + 1) % CAPACITY;
      end
      res.hit     = slot_taken[slot];
      res.slot    = slot[SLOT_W-1:0];
      res.refused = 1'b0;
      if (f == FUNC_INSERT && !res.hit) begin
         if (stored_count >= CAPACITY / 2) begin
            res.refused = 1'b1;
         end else begin
            digest_table[slot] = d;
            slot_taken[slot]   = 1'b1;
            stored_count++;
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] fresh_word();
      return {$urandom, $urandom};
   endfunction

   // Keeps the first 'keep' words of base and redraws the rest until the
   // digest lands on the wanted home slot
   function automatic digest_type digest_homed(input digest_type base, input int keep,
                                               input int target);
      digest_type d;
      int         k;
      d = base;
      do begin
         for (k = keep; k < DIGEST_WORDS; k++) d[k] = fresh_word();
      end while (home_slot(d) != target);
      return d;
   endfunction

   // Random digest for the random phases
   function automatic digest_type choose_digest();
      digest_type d;
      digest_type pick;
      int         roll;
      int         k;
      pick = digest_pool[$urandom_range(digest_pool.size() - 1)];
      roll = $urandom_range(99);
      if (roll < 35) begin
         d = pick;
      end else if (roll < 55) begin
         for (k = 0; k < DIGEST_WORDS; k++) d[k] = fresh_word();
      end else if (roll < 75) begin
         d = digest_homed('0, 0, home_slot(pick));
      end else if (roll < 87) begin
         d = digest_homed(pick, $urandom_range(1, DIGEST_WORDS - 1), home_slot(pick));
      end else if (roll < 93) begin
         d = digest_homed('0, 0, CAPACITY - 1);
      end else begin
         // word-level extremes
         for (k = 0; k < DIGEST_WORDS; k++) begin
            case ($urandom_range(3))
               0:       d[k] = '0;
               1:       d[k] = '1;
               2:       d[k] = 64'h1 << $urandom_range(63);
               default: d[k] = fresh_word();
            endcase
         end
      end
      return d;
   endfunction

   // Offer one request transaction and hold it until accepted
   task automatic offer_request(input func_type f, input digest_type d, input logic typed,
                                input logic typed_hit, input logic typed_refused);
      probe_result_type want;
      req_valid     <= 1'b1;
      req_func      <= f;
      req_digest_w0 <= d[0];
      req_digest_w1 <= d[1];
      req_digest_w2 <= d[2];
      req_digest_w3 <= d[3];
      do @(posedge clock); while (req_stall !== 1'b0);
      want = predict_request(f, d);
      if (typed) begin
         want.hit     = typed_hit;
         want.refused = typed_refused;
      end
      expected_results.push_back(want);
      digest_pool.push_back(d);
      if (f == FUNC_INSERT) inserts_sent++;
      else lookups_sent++;
      if (want.hit) hits_predicted++;
      if (want.refused) refusals_predicted++;
      // optional gap after the transaction
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Sender pauses until every predicted result has come back
   task automatic settle_all();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int items, input int idle_pct, input int stall_pct);
      func_type f;
      send_idle_pct = idle_pct;
      rsp_stall_pct <= stall_pct;
      repeat (items) begin
         f = $urandom_range(1) ? FUNC_INSERT : FUNC_LOOKUP;
         offer_request(f, choose_digest(), 1'b0, 1'b0, 1'b0);
      end
      settle_all();
   endtask

   function automatic void compare_field(input string field, input logic [SLOT_W-1:0] want,
                                         input logic [SLOT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   // Result side: check accepted transactions, drive stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin : check_rsp
            probe_result_type want;
            if (expected_results.size() == 0) begin
               $display("%0t: stray result, expected none, actual hit=%0b slot=%0d refused=%0b",
                        $time, rsp_hit, rsp_slot_index, rsp_refused);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               compare_field("hit", want.hit, rsp_hit);
               compare_field("slot_index", want.slot, rsp_slot_index);
               compare_field("refused", want.refused, rsp_refused);
               results_checked++;
            end
         end
         rsp_stall <= rsp_hold || ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= TIMEOUT_CYCLES);
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_results.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      directed_row_type row;
      digest_type       d;
      int               r;
      for (r = 0; r < CAPACITY; r++) slot_taken[r] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (r = 0; r < DIRECTED_ROWS; r++) begin
         row = directed_rows[r];
         case (row.src)
            SRC_WORDS: d = row.words;
            SRC_AGAIN: d = row_digest[row.ref_row];
            SRC_HOMED: d = digest_homed('0, 0, int'(row.arg));
            default:   d = digest_homed(row_digest[row.ref_row], int'(row.arg),
                                        home_slot(row_digest[row.ref_row]));
         endcase
         row_digest[r] = d;
         offer_request(row.func, d, row.typed, row.hit, row.refused);
      end
      settle_all();

      // Random phases
      run_phase(300, 0, 0);
      run_phase(250, 72, 0);
      run_phase(250, 0, 72);
      run_phase(300, 22, 22);
      // long receiver hold-off while the sender keeps offering
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         run_phase(40, 0, 0);
      join
      run_phase(200, 22, 22);

      settle_all();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d results for %0d lookups and %0d inserts: %0d hits, %0d refusals.",
               results_checked, lookups_sent, inserts_sent, hits_predicted, refusals_predicted);
      $display("Table held %0d of %0d slots; ran idle and stall phases and a %0d-cycle hold-off.",
               stored_count, CAPACITY, LONG_HOLD);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
